// ----- sv/speed_loop_filtered_pi_top_macros.svh -----
// Assertion macros for the speed loop PI controller.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef SPEED_LOOP_FILTERED_PI_TOP_MACROS_SVH
`define SPEED_LOOP_FILTERED_PI_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLFPI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLFPI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/slfpi_pkg.sv -----
// Shared types, constants and helpers of the speed loop PI controller.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package slfpi_pkg;

    // Filter weights in Q0.16: 0.3 for the new error and 0.7 for the old value.
    localparam logic signed [31:0] W_NEW = 32'sd19661;
    localparam logic signed [31:0] W_OLD = 32'sd45875;

    // Register reset values.
    localparam logic signed [15:0] TARGET_RESET = 16'sd0;
    localparam logic signed [31:0] KP_RESET     = -32'sd524288;
    localparam logic signed [31:0] KI_RESET     = -32'sd2621;
    localparam logic [14:0]        LIMIT_RESET  = 15'd1400;

    // Register indexes.
    localparam int REG_TARGET = 0;
    localparam int REG_KP     = 1;
    localparam int REG_KI     = 2;
    localparam int REG_LIMIT  = 3;

    // Default width of the configuration index.
    localparam int CFG_IDX_W_DEF = 8;

    // Datapath widths.
    localparam int ERR_W  = 18;
    localparam int FILT_W = 19;
    localparam int INTG_W = 16;
    localparam int MULB_W = 20;
    localparam int PROD_W = 52;
    localparam int ACC_W  = 53;
    localparam int QUO_W  = ACC_W - 16;

    // Multiplier operand selection.
    typedef logic [1:0] mul_sel_t;
    localparam mul_sel_t MUL_ERR  = 2'd0;
    localparam mul_sel_t MUL_FILT = 2'd1;
    localparam mul_sel_t MUL_KP   = 2'd2;
    localparam mul_sel_t MUL_KI   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     filt_load;
        logic     integ_load;
        logic     out_load;
    } slfpi_cmd_t;

    // Divide a Q16 accumulator by 2^16, rounding toward zero.
    function automatic logic signed [QUO_W-1:0] trunc_q16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] biased;
        biased = v + (v[ACC_W-1] ? ACC_W'(16'hFFFF) : ACC_W'(0));
        return QUO_W'(biased >>> 16);
    endfunction

endpackage

`default_nettype wire

// ----- sv/slfpi_ctrl.sv -----
// Sequencer of the speed loop PI controller: steps the shared multiplier and
// owns the handshakes. Depends on slfpi_pkg and the assertion macro header.
`default_nettype none
`include "speed_loop_filtered_pi_top_macros.svh"

module slfpi_ctrl
    import slfpi_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output slfpi_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL1  = 3'd1;
    localparam logic [2:0] ST_MUL2  = 3'd2;
    localparam logic [2:0] ST_FILT  = 3'd3;
    localparam logic [2:0] ST_INTEG = 3'd4;
    localparam logic [2:0] ST_MUL4  = 3'd5;
    localparam logic [2:0] ST_ADD2  = 3'd6;
    localparam logic [2:0] ST_DRIVE = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_ERR;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERR;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_FILT;
                cmd.acc_load = 1'b1;
                state_next   = ST_FILT;
            end
            ST_FILT: begin
                cmd.filt_load = 1'b1;
                state_next    = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.integ_load = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_KP;
                state_next     = ST_MUL4;
            end
            ST_MUL4: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_KI;
                cmd.acc_load = 1'b1;
                state_next   = ST_ADD2;
            end
            ST_ADD2: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DRIVE;
            end
            ST_DRIVE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output valid flag is set on a load and cleared when the request is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `SLFPI_ASSERT_NOW(a_load_needs_room, aclk, aresetn, cmd.out_load, out_free,
        "result loaded over a pending request")
    `SLFPI_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready,
        state_reg == ST_MUL1, "accepted request did not start the sequence")
    `SLFPI_ASSERT_NEXT(a_drive_waits, aclk, aresetn,
        state_reg == ST_DRIVE && m_tvalid_reg && !m_tready,
        state_reg == ST_DRIVE && m_tvalid_reg, "stalled result was not held")
    `SLFPI_ASSERT_NOW(a_one_update, aclk, aresetn, 1'b1,
        $onehot0({cmd.load_in, cmd.filt_load, cmd.integ_load, cmd.out_load}),
        "more than one state update in a cycle")

endmodule

`default_nettype wire

// ----- sv/slfpi_dp.sv -----
// Datapath of the speed loop PI controller: configuration registers, shared
// multiplier, accumulator, filter and integral state. Depends on slfpi_pkg.
`default_nettype none

module slfpi_dp
    import slfpi_pkg::*;
#(
    parameter int CFG_IDX_W = CFG_IDX_W_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire slfpi_cmd_t            cmd,
    input  wire logic signed [15:0]    left_count,
    input  wire logic signed [15:0]    right_count,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]           cfg_data,
    output logic signed [31:0]         drive,
    output logic                       integral_clamped
);

    logic signed [15:0]        target_reg;
    logic signed [31:0]        kp_reg;
    logic signed [31:0]        ki_reg;
    logic [14:0]               limit_reg;

    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [FILT_W-1:0]  filt_reg, filt_next;
    logic signed [INTG_W-1:0]  integ_reg, integ_next;
    logic                      clamp_reg, clamp_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, acc_sum;
    logic signed [31:0]        drive_reg, drive_next;
    logic                      clamped_out_reg;

    logic signed [31:0]        mul_a;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [QUO_W-1:0]   filt_quo, drive_quo;
    logic signed [MULB_W-1:0]  integ_sum, lim_pos, lim_neg;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
            kp_reg     <= KP_RESET;
            ki_reg     <= KI_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_IDX_W'(REG_TARGET)) target_reg <= cfg_data[15:0];
            if (cfg_index == CFG_IDX_W'(REG_KP))     kp_reg     <= cfg_data;
            if (cfg_index == CFG_IDX_W'(REG_KI))     ki_reg     <= cfg_data;
            if (cfg_index == CFG_IDX_W'(REG_LIMIT))  limit_reg  <= cfg_data[14:0];
        end
    end

    // Speed error of the accepted sample.
    assign err_next = ERR_W'(left_count) + ERR_W'(right_count) - ERR_W'(target_reg);

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_ERR: begin
                mul_a = W_NEW;
                mul_b = MULB_W'(err_reg);
            end
            MUL_FILT: begin
                mul_a = W_OLD;
                mul_b = MULB_W'(filt_reg);
            end
            MUL_KP: begin
                mul_a = kp_reg;
                mul_b = MULB_W'(filt_reg);
            end
            MUL_KI: begin
                mul_a = ki_reg;
                mul_b = MULB_W'(integ_reg);
            end
            default: begin
                mul_a = W_NEW;
                mul_b = MULB_W'(err_reg);
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Accumulator: load a product, or add the next one.
    assign acc_sum = acc_reg + ACC_W'(prod_reg);
    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_load) begin
            acc_next = ACC_W'(prod_reg);
        end else if (cmd.acc_add) begin
            acc_next = acc_sum;
        end
    end

    // Filtered error: weighted sum divided by 2^16 toward zero.
    assign filt_quo  = trunc_q16(acc_sum);
    assign filt_next = filt_quo[FILT_W-1:0];

    // Integral update with the symmetric clamp.
    assign integ_sum = MULB_W'(integ_reg) + MULB_W'(filt_reg);
    assign lim_pos   = MULB_W'({1'b0, limit_reg});
    assign lim_neg   = -lim_pos;
    always_comb begin
        integ_next = integ_sum[INTG_W-1:0];
        clamp_next = 1'b0;
        if (integ_sum > lim_pos) begin
            integ_next = lim_pos[INTG_W-1:0];
            clamp_next = 1'b1;
        end else if (integ_sum < lim_neg) begin
            integ_next = lim_neg[INTG_W-1:0];
            clamp_next = 1'b1;
        end
    end

    // Drive: sum of products divided by 2^16, saturated to 32 bits.
    assign drive_quo = trunc_q16(acc_reg);
    always_comb begin
        drive_next = drive_quo[31:0];
        if (drive_quo[QUO_W-1:31] != {(QUO_W-31){drive_quo[31]}}) begin
            drive_next = drive_quo[QUO_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // Loop state, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg  <= '0;
            integ_reg <= '0;
        end else begin
            if (cmd.filt_load)  filt_reg  <= filt_next;
            if (cmd.integ_load) integ_reg <= integ_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_in)    err_reg   <= err_next;
        if (cmd.mul_en)     prod_reg  <= prod_next;
        acc_reg <= acc_next;
        if (cmd.integ_load) clamp_reg <= clamp_next;
        if (cmd.out_load) begin
            drive_reg       <= drive_next;
            clamped_out_reg <= clamp_reg;
        end
    end

    assign drive            = drive_reg;
    assign integral_clamped = clamped_out_reg;

endmodule

`default_nettype wire

// ----- sv/speed_loop_filtered_pi_top.sv -----
// Top level of the speed loop PI controller with error low-pass and integral clamp.
// Instantiates slfpi_ctrl and slfpi_dp; depends on slfpi_pkg.
//
//  Channel  Direction  Payload                                   Handshake
//  s_       in         tdata: left_count, right_count            s_tvalid/s_tready
//  m_       out        tdata: drive; tuser: integral_clamped     m_tvalid/m_tready
//  cfg_     in         cfg_index, cfg_data                       cfg_valid/cfg_ready
//
// Between the accepting edge of a request and the load of its result register lie the four
// passes through the single shared 32x20 multiplier and the filter, clamp and sum steps.
// A new request is accepted only once the previous one has loaded its result.
// A result that is not taken holds the sequencer in its last step; the next
// request is already accepted while the previous result still waits.
// Reset is synchronous and active low; cfg_ready is always high.
`default_nettype none

module speed_loop_filtered_pi_top
    import slfpi_pkg::*;
#(
    parameter int CFG_IDX_W = CFG_IDX_W_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // tdata: [15:0] left_count, [31:16] right_count
    input  wire logic [31:0]           s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: [31:0] drive
    output logic [31:0]                m_tdata,
    // tuser: [0] integral_clamped
    output logic [0:0]                 m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]           cfg_data
);

    slfpi_cmd_t          cmd;
    logic signed [31:0]  drive;
    logic                integral_clamped;

    assign cfg_ready = 1'b1;

    slfpi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    slfpi_dp #(
        .CFG_IDX_W (CFG_IDX_W)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .left_count       (s_tdata[15:0]),
        .right_count      (s_tdata[31:16]),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .drive            (drive),
        .integral_clamped (integral_clamped)
    );

    assign m_tdata    = drive;
    assign m_tuser[0] = integral_clamped;

endmodule

`default_nettype wire
